// ===== rtl/q2r_pkg.sv =====
// ----------------------------------------------------------------------------
// q2r_pkg
// shared constants, codes and helpers of the quadric evaluator and root solver
// ----------------------------------------------------------------------------
package q2r_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;

    // rounded product term: magnitude clamped to 2^59, signed
    localparam int TERM_W = 61;
    localparam logic [95:0] TERM_LIM = 96'd1 << 59;
    localparam logic [95:0] HALF_LIN = 96'd1 << (FRAC_BITS - 1);
    localparam logic [95:0] HALF_QUAD = 96'd1 << (2 * FRAC_BITS - 1);

    // square root and divider sizes
    localparam int SQ_STEPS = 32;
    localparam int DEN_W = 33;
    localparam int NUM_W = 35 + FRAC_BITS;

    // configuration register file
    localparam int NUM_REGS = 6;
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_COEF_XX = 3'd0;
    localparam logic [2:0] REG_COEF_YY = 3'd1;
    localparam logic [2:0] REG_COEF_XY = 3'd2;
    localparam logic [2:0] REG_COEF_X = 3'd3;
    localparam logic [2:0] REG_COEF_Y = 3'd4;
    localparam logic [2:0] REG_COEF_CONST = 3'd5;

    // query modes
    localparam logic [1:0] MODE_VALUE = 2'd0;
    localparam logic [1:0] MODE_DERIV = 2'd1;
    localparam logic [1:0] MODE_ROOTS = 2'd2;

    localparam logic AXIS_X = 1'b0;

    // saturate a 64 bit signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            r = 32'h7fff_ffff;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // sign extend a rounded term to 64 bits
    function automatic logic signed [63:0] ext_term(input logic signed [TERM_W-1:0] t);
        return {{(64 - TERM_W){t[TERM_W-1]}}, t};
    endfunction

    // sign extend a 32 bit value to 64 bits
    function automatic logic signed [63:0] ext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

// ===== rtl/q2r_term.sv =====
// ----------------------------------------------------------------------------
// q2r_term
// four stage product unit: 64x32 product, rounded half away from zero, clamped
// ----------------------------------------------------------------------------
module q2r_term (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [63:0]                   i_a,
    input  logic signed [31:0]                   i_b,
    input  logic                                 i_quad,
    output logic signed [q2r_pkg::TERM_W-1:0]    o_term
);
    import q2r_pkg::*;

    logic signed [64:0] r_pp_lo;
    logic signed [63:0] r_pp_hi;
    logic [95:0]        r_prod;
    logic [95:0]        r_mag;
    logic               r_neg;
    logic [95:0]        n_sum;
    logic [95:0]        n_q;
    logic [59:0]        n_m;

    // rounding and clamp of the magnitude
    always_comb begin
        n_sum = r_mag + (i_quad ? HALF_QUAD : HALF_LIN);
        n_q = i_quad ? (n_sum >> (2 * FRAC_BITS)) : (n_sum >> FRAC_BITS);
        n_m = (n_q > TERM_LIM) ? TERM_LIM[59:0] : n_q[59:0];
    end

    // partial products, full product, magnitude, rounded term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_lo <= $signed({1'b0, i_a[31:0]}) * i_b;
            r_pp_hi <= $signed(i_a[63:32]) * i_b;
            r_prod  <= {r_pp_hi, 32'd0} + {{31{r_pp_lo[64]}}, r_pp_lo};
            r_neg   <= r_prod[95];
            r_mag   <= r_prod[95] ? (~r_prod + 96'd1) : r_prod;
            o_term  <= r_neg ? -$signed({1'b0, n_m}) : $signed({1'b0, n_m});
        end
    end

endmodule

// ===== rtl/q2r_div.sv =====
// ----------------------------------------------------------------------------
// q2r_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module q2r_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [q2r_pkg::NUM_W-1:0]     i_num,
    input  logic [q2r_pkg::DEN_W-1:0]     i_den,
    output logic [q2r_pkg::NUM_W-1:0]     o_quo
);
    import q2r_pkg::*;

    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W:0]   r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    logic [NUM_W-1:0] s_num [NUM_W];
    logic [NUM_W-1:0] s_quo [NUM_W];
    logic [DEN_W:0]   s_rem [NUM_W];
    logic [DEN_W-1:0] s_den [NUM_W];

    logic [NUM_W-1:0] n_num [NUM_W];
    logic [NUM_W-1:0] n_quo [NUM_W];
    logic [DEN_W:0]   n_rem [NUM_W];
    logic [DEN_W:0]   n_try [NUM_W];

    // stage sources
    always_comb begin
        for (int j = 0; j < NUM_W; j++) begin
            if (j == 0) begin
                s_num[j] = i_num;
                s_quo[j] = '0;
                s_rem[j] = '0;
                s_den[j] = i_den;
            end else begin
                s_num[j] = r_num[j-1];
                s_quo[j] = r_quo[j-1];
                s_rem[j] = r_rem[j-1];
                s_den[j] = r_den[j-1];
            end
        end
    end

    // one trial subtraction per stage
    always_comb begin
        for (int j = 0; j < NUM_W; j++) begin
            n_try[j] = {s_rem[j][DEN_W-1:0], s_num[j][NUM_W-1]};
            n_num[j] = s_num[j] << 1;
            if (n_try[j] >= {1'b0, s_den[j]}) begin
                n_rem[j] = n_try[j] - {1'b0, s_den[j]};
                n_quo[j] = {s_quo[j][NUM_W-2:0], 1'b1};
            end else begin
                n_rem[j] = n_try[j];
                n_quo[j] = {s_quo[j][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NUM_W; j++) begin
                r_num[j] <= n_num[j];
                r_quo[j] <= n_quo[j];
                r_rem[j] <= n_rem[j];
                r_den[j] <= s_den[j];
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule

// ===== rtl/quadric_2d_eval_and_interval_roots.sv =====
// ----------------------------------------------------------------------------
// quadric_2d_eval_and_interval_roots
// value, partial derivative and interval roots of a two variable quadratic
// ----------------------------------------------------------------------------
// data words are signed Q16.16 fixed point (FRAC_BITS = 16)
// throughput: one word per cycle while the result is not stalled; the longest path
//   is the pipelined square root (32 stages) followed by the pipelined divider (FRAC_BITS + 35 stages)
// a stalled result freezes the whole pipeline; nothing is lost or repeated
// reset: synchronous active low, clears valid bits and the coefficients
module quadric_2d_eval_and_interval_roots (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [q2r_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_axis,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic signed [31:0] i_interval_low,
    input  logic signed [31:0] i_interval_high,
    // result words
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_value,
    output logic [1:0]  o_root_count,
    output logic signed [31:0] o_root_first,
    output logic signed [31:0] o_root_second
);
    import q2r_pkg::*;

    typedef struct packed {
        logic        vld;
        logic [1:0]  mode;
        logic        axis;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_in_side;

    typedef struct packed {
        logic        vld;
        logic        ok;
        logic        lin;
        logic [31:0] val;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_root_side;

    logic signed [31:0] r_coef [NUM_REGS];
    logic en;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                if (paddr[ADDR_W-1:2] == 3'(k)) begin
                    r_coef[k] <= pwdata;
                end
            end
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_COEF_XX:    prdata = r_coef[REG_COEF_XX];
            REG_COEF_YY:    prdata = r_coef[REG_COEF_YY];
            REG_COEF_XY:    prdata = r_coef[REG_COEF_XY];
            REG_COEF_X:     prdata = r_coef[REG_COEF_X];
            REG_COEF_Y:     prdata = r_coef[REG_COEF_Y];
            REG_COEF_CONST: prdata = r_coef[REG_COEF_CONST];
            default:        prdata = '0;
        endcase
    end

    // global pipeline advance
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 1: input register, stage 2: coordinate products
    t_in_side r_s1_side, r_s2_side;
    t_in_side r_side_d [4];
    logic signed [31:0] r_s1_x, r_s1_y, r_s2_x, r_s2_y;
    logic signed [63:0] r_s2_xx, r_s2_yy, r_s2_xy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side <= '0;
            r_s2_side <= '0;
            for (int k = 0; k < 4; k++) begin
                r_side_d[k] <= '0;
            end
        end else if (en) begin
            r_s1_side <= '{vld: i_valid, mode: i_mode, axis: i_axis,
                           lo: i_interval_low, hi: i_interval_high};
            r_s2_side <= r_s1_side;
            r_side_d[0] <= r_s2_side;
            for (int k = 1; k < 4; k++) begin
                r_side_d[k] <= r_side_d[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x  <= i_x_coord;
            r_s1_y  <= i_y_coord;
            r_s2_x  <= r_s1_x;
            r_s2_y  <= r_s1_y;
            r_s2_xx <= r_s1_x * r_s1_x;
            r_s2_yy <= r_s1_y * r_s1_y;
            r_s2_xy <= r_s1_x * r_s1_y;
        end
    end

    // stages 3 to 6: rounded product terms
    logic signed [TERM_W-1:0] t_q0, t_q1, t_q2, t_lx3, t_ly4, t_ly2, t_lx2, t_d0, t_d1;
    logic signed [63:0] w_x, w_y, w_x2, w_y2;

    assign w_x  = ext32(r_s2_x);
    assign w_y  = ext32(r_s2_y);
    assign w_x2 = {{31{r_s2_x[31]}}, r_s2_x, 1'b0};
    assign w_y2 = {{31{r_s2_y[31]}}, r_s2_y, 1'b0};

    q2r_term u_q0 (.i_clk, .i_en(en), .i_a(r_s2_xx), .i_b(r_coef[REG_COEF_XX]),
                   .i_quad(1'b1), .o_term(t_q0));
    q2r_term u_q1 (.i_clk, .i_en(en), .i_a(r_s2_yy), .i_b(r_coef[REG_COEF_YY]),
                   .i_quad(1'b1), .o_term(t_q1));
    q2r_term u_q2 (.i_clk, .i_en(en), .i_a(r_s2_xy), .i_b(r_coef[REG_COEF_XY]),
                   .i_quad(1'b1), .o_term(t_q2));
    q2r_term u_lx3 (.i_clk, .i_en(en), .i_a(w_x), .i_b(r_coef[REG_COEF_X]),
                    .i_quad(1'b0), .o_term(t_lx3));
    q2r_term u_ly4 (.i_clk, .i_en(en), .i_a(w_y), .i_b(r_coef[REG_COEF_Y]),
                    .i_quad(1'b0), .o_term(t_ly4));
    q2r_term u_ly2 (.i_clk, .i_en(en), .i_a(w_y), .i_b(r_coef[REG_COEF_XY]),
                    .i_quad(1'b0), .o_term(t_ly2));
    q2r_term u_lx2 (.i_clk, .i_en(en), .i_a(w_x), .i_b(r_coef[REG_COEF_XY]),
                    .i_quad(1'b0), .o_term(t_lx2));
    q2r_term u_d0 (.i_clk, .i_en(en), .i_a(w_x2), .i_b(r_coef[REG_COEF_XX]),
                   .i_quad(1'b0), .o_term(t_d0));
    q2r_term u_d1 (.i_clk, .i_en(en), .i_a(w_y2), .i_b(r_coef[REG_COEF_YY]),
                   .i_quad(1'b0), .o_term(t_d1));

    // stage 7: exact sums
    t_in_side r_s7_side;
    logic signed [63:0] r_s7_val, r_s7_b, r_s7_c;
    logic signed [63:0] n_s7_val, n_s7_b, n_s7_c;
    logic signed [63:0] w_c5;

    assign w_c5 = ext32(r_coef[REG_COEF_CONST]);

    always_comb begin
        if (r_side_d[3].mode == MODE_VALUE) begin
            n_s7_val = ext_term(t_q0) + ext_term(t_q1) + ext_term(t_q2)
                     + ext_term(t_lx3) + ext_term(t_ly4) + w_c5;
        end else if (r_side_d[3].axis == AXIS_X) begin
            n_s7_val = ext_term(t_d0) + ext_term(t_ly2) + ext32(r_coef[REG_COEF_X]);
        end else begin
            n_s7_val = ext_term(t_d1) + ext_term(t_lx2) + ext32(r_coef[REG_COEF_Y]);
        end
        if (r_side_d[3].axis == AXIS_X) begin
            n_s7_b = ext_term(t_ly2) + ext32(r_coef[REG_COEF_X]);
            n_s7_c = ext_term(t_q1) + ext_term(t_ly4) + w_c5;
        end else begin
            n_s7_b = ext_term(t_lx2) + ext32(r_coef[REG_COEF_Y]);
            n_s7_c = ext_term(t_q0) + ext_term(t_lx3) + w_c5;
        end
    end

    // stage 8: saturation, stage 9: discriminant products
    t_in_side r_s8_side, r_s9_side;
    logic signed [31:0] r_s8_val, r_s8_a, r_s8_b, r_s8_c;
    logic signed [31:0] r_s9_val, r_s9_a, r_s9_b, r_s9_c;
    logic signed [63:0] r_s9_bb, r_s9_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_side <= '0;
            r_s8_side <= '0;
            r_s9_side <= '0;
        end else if (en) begin
            r_s7_side <= r_side_d[3];
            r_s8_side <= r_s7_side;
            r_s9_side <= r_s8_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_val <= n_s7_val;
            r_s7_b   <= n_s7_b;
            r_s7_c   <= n_s7_c;
            r_s8_val <= (r_s7_side.mode == MODE_VALUE || r_s7_side.mode == MODE_DERIV)
                      ? sat32(r_s7_val) : 32'd0;
            r_s8_b   <= sat32(r_s7_b);
            r_s8_c   <= sat32(r_s7_c);
            r_s8_a   <= (r_s7_side.axis == AXIS_X) ? r_coef[REG_COEF_XX]
                                                   : r_coef[REG_COEF_YY];
            r_s9_val <= r_s8_val;
            r_s9_a   <= r_s8_a;
            r_s9_b   <= r_s8_b;
            r_s9_c   <= r_s8_c;
            r_s9_bb  <= r_s8_b * r_s8_b;
            r_s9_ac  <= r_s8_a * r_s8_c;
        end
    end

    // stage 10: discriminant and case flags, then square root stages
    t_root_side         r_sq_side [SQ_STEPS+1];
    logic [63:0]        r_sq_rad  [SQ_STEPS+1];
    logic [34:0]        r_sq_rem  [SQ_STEPS+1];
    logic [31:0]        r_sq_root [SQ_STEPS+1];
    logic signed [31:0] r_sq_a    [SQ_STEPS+1];
    logic signed [31:0] r_sq_b    [SQ_STEPS+1];
    logic signed [31:0] r_sq_c    [SQ_STEPS+1];
    logic signed [63:0] n_s10_d;
    logic               n_s10_ok;
    logic [34:0]        n_sq_try [SQ_STEPS];
    logic [34:0]        n_sq_rem [SQ_STEPS];
    logic [31:0]        n_sq_root [SQ_STEPS];

    always_comb begin
        n_s10_d  = $signed({2'b00, r_s9_bb[63:2]}) - r_s9_ac;
        n_s10_ok = (r_s9_side.mode == MODE_ROOTS) && !n_s10_d[63]
                && !(r_s9_a == 32'sd0 && r_s9_b == 32'sd0);
    end

    // one root digit per stage
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            n_sq_try[k] = {r_sq_rem[k][32:0], r_sq_rad[k][63:62]};
            if (n_sq_try[k] >= {1'b0, r_sq_root[k], 2'b01}) begin
                n_sq_rem[k]  = n_sq_try[k] - {1'b0, r_sq_root[k], 2'b01};
                n_sq_root[k] = {r_sq_root[k][30:0], 1'b1};
            end else begin
                n_sq_rem[k]  = n_sq_try[k];
                n_sq_root[k] = {r_sq_root[k][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_sq_side[k] <= '0;
            end
        end else if (en) begin
            r_sq_side[0] <= '{vld: r_s9_side.vld, ok: n_s10_ok, lin: (r_s9_a == 32'sd0),
                              val: r_s9_val, lo: r_s9_side.lo, hi: r_s9_side.hi};
            for (int k = 1; k <= SQ_STEPS; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rad[0]  <= n_s10_d;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_a[0]    <= r_s9_a;
            r_sq_b[0]    <= r_s9_b;
            r_sq_c[0]    <= r_s9_c;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                r_sq_rad[k]  <= r_sq_rad[k-1] << 2;
                r_sq_rem[k]  <= n_sq_rem[k-1];
                r_sq_root[k] <= n_sq_root[k-1];
                r_sq_a[k]    <= r_sq_a[k-1];
                r_sq_b[k]    <= r_sq_b[k-1];
                r_sq_c[k]    <= r_sq_c[k-1];
            end
        end
    end

    // numerators and denominator of the two roots
    t_root_side         r_rp0_side, r_rp1_side;
    logic signed [34:0] r_rp0_n0, r_rp0_n1;
    logic signed [33:0] r_rp0_d;
    logic [NUM_W-1:0]   r_rp1_num0, r_rp1_num1;
    logic [DEN_W-1:0]   r_rp1_den;
    logic               r_rp1_neg0, r_rp1_neg1;
    logic signed [34:0] w_nb, w_s;
    logic [33:0]        n_un0, n_un1;
    logic [DEN_W-1:0]   n_ud;

    assign w_nb = -{{3{r_sq_b[SQ_STEPS][31]}}, r_sq_b[SQ_STEPS]};
    assign w_s  = $signed({2'b00, r_sq_root[SQ_STEPS], 1'b0});

    always_comb begin
        n_un0 = r_rp0_n0[34] ? 34'(-r_rp0_n0) : r_rp0_n0[33:0];
        n_un1 = r_rp0_n1[34] ? 34'(-r_rp0_n1) : r_rp0_n1[33:0];
        n_ud  = r_rp0_d[33] ? 33'(-r_rp0_d) : r_rp0_d[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp0_side <= '0;
            r_rp1_side <= '0;
        end else if (en) begin
            r_rp0_side <= r_sq_side[SQ_STEPS];
            r_rp1_side <= r_rp0_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_sq_side[SQ_STEPS].lin) begin
                r_rp0_n0 <= -{{3{r_sq_c[SQ_STEPS][31]}}, r_sq_c[SQ_STEPS]};
                r_rp0_n1 <= -{{3{r_sq_c[SQ_STEPS][31]}}, r_sq_c[SQ_STEPS]};
                r_rp0_d  <= {{2{r_sq_b[SQ_STEPS][31]}}, r_sq_b[SQ_STEPS]};
            end else begin
                r_rp0_n0 <= w_nb + w_s;
                r_rp0_n1 <= w_nb - w_s;
                r_rp0_d  <= {r_sq_a[SQ_STEPS][31], r_sq_a[SQ_STEPS], 1'b0};
            end
            r_rp1_num0 <= (NUM_W'(n_un0) << FRAC_BITS) + NUM_W'(n_ud >> 1);
            r_rp1_num1 <= (NUM_W'(n_un1) << FRAC_BITS) + NUM_W'(n_ud >> 1);
            r_rp1_den  <= n_ud;
            r_rp1_neg0 <= r_rp0_n0[34] ^ r_rp0_d[33];
            r_rp1_neg1 <= r_rp0_n1[34] ^ r_rp0_d[33];
        end
    end

    // root dividers
    logic [NUM_W-1:0] w_q0, w_q1;

    q2r_div u_div0 (.i_clk, .i_en(en), .i_num(r_rp1_num0), .i_den(r_rp1_den), .o_quo(w_q0));
    q2r_div u_div1 (.i_clk, .i_en(en), .i_num(r_rp1_num1), .i_den(r_rp1_den), .o_quo(w_q1));

    t_root_side r_dv_side [NUM_W];
    logic       r_dv_neg0 [NUM_W];
    logic       r_dv_neg1 [NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_dv_side[k] <= '0;
            end
        end else if (en) begin
            r_dv_side[0] <= r_rp1_side;
            for (int k = 1; k < NUM_W; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_neg0[0] <= r_rp1_neg0;
            r_dv_neg1[0] <= r_rp1_neg1;
            for (int k = 1; k < NUM_W; k++) begin
                r_dv_neg0[k] <= r_dv_neg0[k-1];
                r_dv_neg1[k] <= r_dv_neg1[k-1];
            end
        end
    end

    // saturate quotients to signed 32 bits
    t_root_side         r_rf_side;
    logic signed [31:0] r_rf_c0, r_rf_c1;
    localparam logic [NUM_W-1:0] Q_MAX_POS = NUM_W'(32'h7fff_ffff);
    localparam logic [NUM_W-1:0] Q_MAX_NEG = NUM_W'(33'h1_0000_0000) >> 1;

    function automatic logic [31:0] sat_quo(input logic [NUM_W-1:0] q, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (q > Q_MAX_NEG) ? 32'h8000_0000 : 32'(-q[31:0]);
        end else begin
            r = (q > Q_MAX_POS) ? 32'h7fff_ffff : q[31:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_side <= '0;
        end else if (en) begin
            r_rf_side <= r_dv_side[NUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rf_c0 <= sat_quo(w_q0, r_dv_neg0[NUM_W-1]);
            r_rf_c1 <= sat_quo(w_q1, r_dv_neg1[NUM_W-1]);
        end
    end

    // interval test, dedupe and ordering into the output register
    logic n_acc0, n_acc1;
    logic [1:0] n_cnt;
    logic signed [31:0] n_r0, n_r1;

    always_comb begin
        n_acc0 = r_rf_side.ok && ($signed(r_rf_side.lo) < r_rf_c0)
              && (r_rf_c0 < $signed(r_rf_side.hi));
        n_acc1 = r_rf_side.ok && !r_rf_side.lin
              && ($signed(r_rf_side.lo) < r_rf_c1) && (r_rf_c1 < $signed(r_rf_side.hi))
              && !(n_acc0 && r_rf_c1 == r_rf_c0);
        n_cnt = {1'b0, n_acc0} + {1'b0, n_acc1};
        n_r0 = '0;
        n_r1 = '0;
        if (n_acc0 && n_acc1) begin
            n_r0 = (r_rf_c0 < r_rf_c1) ? r_rf_c0 : r_rf_c1;
            n_r1 = (r_rf_c0 < r_rf_c1) ? r_rf_c1 : r_rf_c0;
        end else if (n_acc0) begin
            n_r0 = r_rf_c0;
        end else if (n_acc1) begin
            n_r0 = r_rf_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_rf_side.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_value       <= r_rf_side.val;
            o_root_count  <= n_cnt;
            o_root_first  <= n_r0;
            o_root_second <= n_r1;
        end
    end

    // checks
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_count == 2'd2 |-> o_root_first < o_root_second)
        else $error("roots out of order");

    a_roots_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_count != 2'd0 |-> o_value == 32'sd0)
        else $error("value set on a root result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_root_count != 2'd3)
        else $error("root count out of range");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rf_side.vld && en |=> o_valid)
        else $error("word lost at output register");

    a_lin_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rf_side.vld && r_rf_side.lin && en |=> o_root_count != 2'd2)
        else $error("linear solve gave two roots");

endmodule

// ===== test/q2r_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q2r_checker
// watches the query and result channels and the register port, predicts every
// result word from its own copy of the coefficients and compares field by field
// ----------------------------------------------------------------------------
module q2r_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [q2r_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_axis,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic signed [31:0] i_interval_low,
    input  logic signed [31:0] i_interval_high,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic signed [31:0] o_value,
    input  logic [1:0]  o_root_count,
    input  logic signed [31:0] o_root_first,
    input  logic signed [31:0] o_root_second,
    output int          o_pending,
    output int          o_errors
);
    import q2r_pkg::*;

    localparam logic [63:0] CLAMP = 64'd1 << 59;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  count;
        logic [31:0] first;
        logic [31:0] second;
    } q2r_word_t;

    logic signed [63:0] coef_copy [NUM_REGS];
    q2r_word_t          expected_words [$];

    // rounded product a*b / 2^s, ties away from zero, magnitude clamped
    function automatic logic signed [63:0] round_term(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input int s);
        logic [127:0] ua, ub, p;
        logic [63:0]  m;
        logic         neg;
        ua  = {64'd0, (a < 0) ? -a : a};
        ub  = {64'd0, (b < 0) ? -b : b};
        neg = (a < 0) != (b < 0);
        p   = ((ua * ub) + (128'd1 << (s - 1))) >> s;
        m   = (p > {64'd0, CLAMP}) ? CLAMP : p[63:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > 64'sh7fff_ffff) return 64'sh7fff_ffff;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // n * 2^FRAC_BITS / d, rounded to nearest, ties away, saturated
    function automatic logic signed [63:0] root_quot(input logic signed [63:0] n,
                                                     input logic signed [63:0] d);
        logic [63:0] un, ud, q;
        logic        neg;
        un  = (n < 0) ? -n : n;
        ud  = (d < 0) ? -d : d;
        neg = (n < 0) != (d < 0);
        q   = ((un << FRAC_BITS) + (ud >> 1)) / ud;
        if (neg) return (q > 64'h8000_0000) ? -64'sh8000_0000 : -$signed(q);
        return (q > 64'h7fff_ffff) ? 64'sh7fff_ffff : $signed(q);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r, t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // expected result word of one query
    function automatic q2r_word_t quadric_result(input logic [1:0] mode, input logic axis,
                                                 input logic signed [63:0] x,
                                                 input logic signed [63:0] y,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
        q2r_word_t          w;
        logic signed [63:0] val, t, a, b, c, disc, s;
        logic signed [63:0] cand [2];
        logic signed [63:0] kept [2];
        int                 sq, lin, own, nr, cnt;
        w   = '0;
        val = 0;
        cnt = 0;
        nr  = 0;
        kept[0] = 0;
        kept[1] = 0;
        if (mode == MODE_VALUE) begin
            val = round_term(x * x, coef_copy[REG_COEF_XX], 2 * FRAC_BITS)
                + round_term(y * y, coef_copy[REG_COEF_YY], 2 * FRAC_BITS)
                + round_term(x * y, coef_copy[REG_COEF_XY], 2 * FRAC_BITS)
                + round_term(x, coef_copy[REG_COEF_X], FRAC_BITS)
                + round_term(y, coef_copy[REG_COEF_Y], FRAC_BITS)
                + coef_copy[REG_COEF_CONST];
            val = clip32(val);
        end else if (mode == MODE_DERIV) begin
            if (axis == AXIS_X) begin
                val = round_term(2 * x, coef_copy[REG_COEF_XX], FRAC_BITS)
                    + round_term(y, coef_copy[REG_COEF_XY], FRAC_BITS)
                    + coef_copy[REG_COEF_X];
            end else begin
                val = round_term(2 * y, coef_copy[REG_COEF_YY], FRAC_BITS)
                    + round_term(x, coef_copy[REG_COEF_XY], FRAC_BITS)
                    + coef_copy[REG_COEF_Y];
            end
            val = clip32(val);
        end else if (mode == MODE_ROOTS) begin
            t   = (axis == AXIS_X) ? y : x;
            sq  = (axis == AXIS_X) ? REG_COEF_YY : REG_COEF_XX;
            lin = (axis == AXIS_X) ? REG_COEF_Y : REG_COEF_X;
            own = (axis == AXIS_X) ? REG_COEF_X : REG_COEF_Y;
            a   = coef_copy[(axis == AXIS_X) ? REG_COEF_XX : REG_COEF_YY];
            b   = clip32(round_term(t, coef_copy[REG_COEF_XY], FRAC_BITS) + coef_copy[own]);
            c   = clip32(round_term(t * t, coef_copy[sq], 2 * FRAC_BITS)
                       + round_term(t, coef_copy[lin], FRAC_BITS)
                       + coef_copy[REG_COEF_CONST]);
            disc = ((b * b) >>> 2) - a * c;
            if (disc >= 0 && !(a == 0 && b == 0)) begin
                if (a == 0) begin
                    cand[0] = root_quot(-c, b);
                    cand[1] = cand[0];
                end else begin
                    s       = 2 * $signed(floor_sqrt(disc));
                    cand[0] = root_quot(-b + s, 2 * a);
                    cand[1] = root_quot(-b - s, 2 * a);
                end
                nr = 2;
            end
            // keep roots strictly inside the interval, each once
            for (int i = 0; i < nr; i++) begin
                if (lo < cand[i] && cand[i] < hi) begin
                    if (!(cnt == 1 && kept[0] == cand[i])) begin
                        kept[cnt] = cand[i];
                        cnt++;
                    end
                end
            end
            if (cnt == 2 && kept[1] < kept[0]) begin
                s       = kept[0];
                kept[0] = kept[1];
                kept[1] = s;
            end
        end
        w.value  = val[31:0];
        w.count  = cnt[1:0];
        w.first  = kept[0][31:0];
        w.second = kept[1][31:0];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // register writes, query words in, result words out
    always @(posedge i_clk) begin
        q2r_word_t w;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) coef_copy[i] = 0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr >> 2) < NUM_REGS)
                coef_copy[paddr >> 2] = {{32{pwdata[31]}}, pwdata};
            if (i_valid && !o_stall)
                expected_words.push_back(quadric_result(i_mode, i_axis, i_x_coord,
                                                        i_y_coord, i_interval_low,
                                                        i_interval_high));
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", o_value, 32'd0);
                end else begin
                    w = expected_words.pop_front();
                    if (o_value !== w.value) report_mismatch("value", o_value, w.value);
                    if (o_root_count !== w.count)
                        report_mismatch("root_count", {30'd0, o_root_count}, {30'd0, w.count});
                    if (o_root_first !== w.first)
                        report_mismatch("root_first", o_root_first, w.first);
                    if (o_root_second !== w.second)
                        report_mismatch("root_second", o_root_second, w.second);
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives register settings and query words into the quadric evaluator with
// random idling on both channels; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb;
    import q2r_pkg::*;

    localparam logic [1:0]  MODE_NONE = 2'd3;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam int DRAIN = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = '0;
    logic        i_axis = 1'b0;
    logic signed [31:0] i_x_coord = '0, i_y_coord = '0;
    logic signed [31:0] i_interval_low = '0, i_interval_high = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_value, o_root_first, o_root_second;
    logic [1:0]  o_root_count;
    int          pending, errors;

    int          no_idle = 0;
    int          long_hold = 0;

    always #6 i_clk = ~i_clk;

    quadric_2d_eval_and_interval_roots dut (.*);

    q2r_checker chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .i_valid, .o_stall, .i_mode, .i_axis, .i_x_coord, .i_y_coord,
        .i_interval_low, .i_interval_high, .o_valid, .i_stall, .o_value,
        .o_root_count, .o_root_first, .o_root_second,
        .o_pending(pending), .o_errors(errors)
    );

    // generous limit
    initial begin
        #(12 * 600000);
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls, one long hold-off when asked
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = (no_idle != 0) ? 0 : $urandom_range(0, 4);
            if (long_hold != 0) begin
                gap = 400;
                long_hold = 0;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for the pipeline to empty, then load all six coefficients
    task automatic load_coefs(input logic [31:0] cxx, cyy, cxy, cx, cy, cc);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        reg_write(REG_COEF_XX, cxx);
        reg_write(REG_COEF_YY, cyy);
        reg_write(REG_COEF_XY, cxy);
        reg_write(REG_COEF_X, cx);
        reg_write(REG_COEF_Y, cy);
        reg_write(REG_COEF_CONST, cc);
    endtask

    task automatic send_word(input logic [1:0] mode, input logic axis,
                             input logic [31:0] x, y, lo, hi);
        int gap;
        gap = (no_idle != 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_axis          <= axis;
        i_x_coord       <= x;
        i_y_coord       <= y;
        i_interval_low  <= lo;
        i_interval_high <= hi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // small values land roots in reach, full range exercises saturation
    function automatic logic [31:0] pick_value(input int wide);
        if (wide != 0) return $urandom;
        return 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
    endfunction

    task automatic random_words(input int n, input int wide);
        logic [1:0]  mode;
        logic [31:0] lo, hi;
        for (int i = 0; i < n; i++) begin
            mode = ($urandom_range(0, 19) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0) begin
                lo = $urandom;
                hi = $urandom;
            end else begin
                lo = 32'($signed($urandom_range(0, 10 * 65536)) - 10 * 65536);
                hi = 32'($signed($urandom_range(0, 10 * 65536)));
            end
            send_word(mode, 1'($urandom), pick_value(wide), pick_value(wide), lo, hi);
        end
    endtask

    task automatic random_coefs(input int wide);
        load_coefs(pick_value(wide), pick_value(wide), pick_value(wide),
                   pick_value(wide), pick_value(wide), pick_value(wide));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero coefficients after reset, unused mode
        send_word(MODE_VALUE, 1'b0, MAXV, MINV, MINV, MAXV);
        send_word(MODE_ROOTS, 1'b0, ONE, ONE, MINV, MAXV);
        send_word(MODE_NONE, 1'b1, MAXV, MAXV, MINV, MAXV);

        // x^2 - 4: roots at -2 and 2
        load_coefs(ONE, 0, 0, 0, 0, -4 * ONE);
        send_word(MODE_ROOTS, 1'b0, 0, 0, -5 * ONE, 5 * ONE);
        send_word(MODE_ROOTS, 1'b0, 0, 0, -2 * ONE, 5 * ONE);
        send_word(MODE_ROOTS, 1'b0, 0, 0, 5 * ONE, -5 * ONE);
        send_word(MODE_ROOTS, 1'b0, 0, 0, ONE, ONE);
        send_word(MODE_VALUE, 1'b0, 3 * ONE, 7 * ONE, 0, 0);
        send_word(MODE_DERIV, 1'b0, 3 * ONE, 0, 0, 0);
        send_word(MODE_DERIV, 1'b1, 3 * ONE, 0, 0, 0);

        // positive constant gives a negative discriminant; zero gives a double root
        load_coefs(ONE, ONE, ONE / 2, 0, 0, 4 * ONE);
        send_word(MODE_ROOTS, 1'b0, 0, 0, -5 * ONE, 5 * ONE);
        send_word(MODE_ROOTS, 1'b1, 0, -4 * ONE, -9 * ONE, 9 * ONE);
        load_coefs(ONE, ONE, 0, 0, 0, 0);
        send_word(MODE_ROOTS, 1'b0, 0, 0, -ONE, ONE);
        send_word(MODE_ROOTS, 1'b1, ONE, 0, -ONE, ONE);

        // linear solve, and a and b both zero
        load_coefs(0, 0, 0, 2 * ONE, 0, -3 * ONE);
        send_word(MODE_ROOTS, 1'b0, 0, 0, -5 * ONE, 5 * ONE);
        send_word(MODE_ROOTS, 1'b1, ONE, 0, -5 * ONE, 5 * ONE);
        send_word(MODE_DERIV, 1'b0, MAXV, MINV, 0, 0);

        // extreme coefficients: clamped terms and saturation
        load_coefs(MAXV, MINV, MAXV, MINV, MAXV, MINV);
        send_word(MODE_VALUE, 1'b0, MAXV, MINV, 0, 0);
        send_word(MODE_VALUE, 1'b1, MINV, MINV, 0, 0);
        send_word(MODE_DERIV, 1'b0, MINV, MAXV, 0, 0);
        send_word(MODE_DERIV, 1'b1, MAXV, MINV, 0, 0);
        send_word(MODE_ROOTS, 1'b0, MAXV, MINV, MINV, MAXV);
        send_word(MODE_ROOTS, 1'b1, MINV, MAXV, MINV, MAXV);

        // burst into a long hold-off so the pipeline fills and stalls
        random_coefs(0);
        no_idle   = 1;
        long_hold = 1;
        random_words(200, 0);
        no_idle = 0;

        random_coefs(1);
        random_words(120, 1);
        random_coefs(0);
        random_words(200, 0);
        load_coefs(MINV, MAXV, MINV, MAXV, MINV, MAXV);
        random_words(100, 1);
        load_coefs(ONE, -ONE, 0, 0, ONE, -ONE);
        random_words(150, 0);
        load_coefs(0, 0, ONE, ONE, -ONE, ONE / 4);
        random_words(150, 0);
        random_coefs(1);
        no_idle = 1;
        random_words(80, 1);
        no_idle = 0;
        random_coefs(0);
        random_words(100, 0);

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
